/* rtl/lhd_pkg.sv */
// ----------------------------------------------------------------------------
// lhd_pkg
// Shared types, codes and defaults of the lightmap hole dilation block.
// ----------------------------------------------------------------------------
package lhd_pkg;

  localparam int PAGE_SIDE_DEF    = 64;
  localparam int CHANNEL_BITS_DEF = 16;

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_RUN   = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  localparam logic RESULT_READ = 1'b0;
  localparam logic RESULT_DONE = 1'b1;

  localparam logic REG_PASS_COUNT  = 1'b0;
  localparam logic REG_SIDE_IN_USE = 1'b1;

  localparam logic [3:0] PASS_COUNT_RST  = 4'd3;
  localparam logic [6:0] SIDE_IN_USE_RST = 7'd64;

  // neighbour slot 0..8 issues a read, slot 9 only collects the last one
  localparam logic [3:0] NB_LAST = 4'd9;

  localparam logic [1:0] OFF_NEG  = 2'd0;
  localparam logic [1:0] OFF_ZERO = 2'd1;
  localparam logic [1:0] OFF_POS  = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [11:0] texel_index;
    logic [15:0] red_in;
    logic [15:0] green_in;
    logic [15:0] blue_in;
    logic        covered_in;
  } req_t;

  typedef struct packed {
    logic        result_kind;
    logic [15:0] red_out;
    logic [15:0] green_out;
    logic [15:0] blue_out;
    logic        covered_out;
  } res_t;

  typedef struct packed {
    logic       host_wr;
    logic       host_rd;
    logic       run_init;
    logic       pass_init;
    logic       cen_rd;
    logic       nb_step;
    logic [3:0] nb_k;
    logic       div_init;
    logic       div_step;
    logic       wb;
    logic       tail_rd;
    logic       tail_wr;
    logic       pass_end;
    logic       load_rd;
    logic       load_fin;
  } cmd_t;

  typedef struct packed {
    logic passes_done;
    logic side_zero;
    logic ccov;
    logic cnt_zero;
    logic last_texel;
    logic tail_done;
    logic out_free;
  } sts_t;

  function automatic logic [1:0] nb_dx(input logic [3:0] k);
    case (k)
      4'd0, 4'd3, 4'd6: nb_dx = OFF_NEG;
      4'd2, 4'd5, 4'd8: nb_dx = OFF_POS;
      default:          nb_dx = OFF_ZERO;
    endcase
  endfunction

  function automatic logic [1:0] nb_dy(input logic [3:0] k);
    case (k)
      4'd0, 4'd1, 4'd2: nb_dy = OFF_NEG;
      4'd6, 4'd7, 4'd8: nb_dy = OFF_POS;
      default:          nb_dy = OFF_ZERO;
    endcase
  endfunction

endpackage

/* rtl/lhd_ctrl.sv */
// ----------------------------------------------------------------------------
// lhd_ctrl
// Sequencer: host requests, pass loop, neighbour reads, divide, tail copy.
// ----------------------------------------------------------------------------
module lhd_ctrl #(
  parameter int CHANNEL_BITS = lhd_pkg::CHANNEL_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic [1:0]    req_mode,
  output logic          req_stall,
  input  lhd_pkg::sts_t sts,
  output lhd_pkg::cmd_t cmd
);
  import lhd_pkg::*;

  localparam int AW     = CHANNEL_BITS + 3;
  localparam int DIVC_W = $clog2(AW + 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RD     = 4'd1;
  localparam logic [3:0] S_PSTART = 4'd2;
  localparam logic [3:0] S_CEN    = 4'd3;
  localparam logic [3:0] S_NB     = 4'd4;
  localparam logic [3:0] S_DEC    = 4'd5;
  localparam logic [3:0] S_DIV    = 4'd6;
  localparam logic [3:0] S_WB     = 4'd7;
  localparam logic [3:0] S_TRD    = 4'd8;
  localparam logic [3:0] S_TWR    = 4'd9;
  localparam logic [3:0] S_FIN    = 4'd10;

  logic [3:0]        state, state_next;
  logic [3:0]        nb_k, nb_k_next;
  logic [DIVC_W-1:0] div_cnt, div_cnt_next;
  logic              accept;

  assign req_stall = (state != S_IDLE) || !sts.out_free;
  assign accept    = req_valid && !req_stall;

  always_comb begin
    state_next   = state;
    nb_k_next    = nb_k;
    div_cnt_next = div_cnt;
    cmd          = '0;
    cmd.nb_k     = nb_k;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req_mode)
            MODE_WRITE: cmd.host_wr = 1'b1;
            MODE_READ: begin
              cmd.host_rd = 1'b1;
              state_next  = S_RD;
            end
            MODE_RUN: begin
              cmd.run_init = 1'b1;
              state_next   = S_PSTART;
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        if (sts.out_free) begin
          cmd.load_rd = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_PSTART: begin
        if (sts.passes_done) begin
          state_next = S_FIN;
        end else begin
          cmd.pass_init = 1'b1;
          state_next    = sts.side_zero ? S_TRD : S_CEN;
        end
      end
      S_CEN: begin
        cmd.cen_rd = 1'b1;
        nb_k_next  = '0;
        state_next = S_NB;
      end
      S_NB: begin
        cmd.nb_step = 1'b1;
        nb_k_next   = nb_k + 4'd1;
        if (nb_k == NB_LAST) begin
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        if (!sts.ccov && !sts.cnt_zero) begin
          cmd.div_init = 1'b1;
          div_cnt_next = '0;
          state_next   = S_DIV;
        end else begin
          state_next = S_WB;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_next = div_cnt + DIVC_W'(1);
        if (div_cnt == DIVC_W'(AW - 1)) begin
          state_next = S_WB;
        end
      end
      S_WB: begin
        cmd.wb     = 1'b1;
        state_next = sts.last_texel ? S_TRD : S_CEN;
      end
      S_TRD: begin
        if (sts.tail_done) begin
          cmd.pass_end = 1'b1;
          state_next   = S_PSTART;
        end else begin
          cmd.tail_rd = 1'b1;
          state_next  = S_TWR;
        end
      end
      S_TWR: begin
        cmd.tail_wr = 1'b1;
        state_next  = S_TRD;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.load_fin = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      nb_k    <= '0;
      div_cnt <= '0;
    end else begin
      state   <= state_next;
      nb_k    <= nb_k_next;
      div_cnt <= div_cnt_next;
    end
  end

`ifndef SYNTHESIS
  a_take_only_idle: assert property (@(posedge clk) disable iff (rst)
    !req_stall |-> state == S_IDLE)
    else $error("request taken outside idle");
  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> div_cnt < DIVC_W'(AW))
    else $error("divide step count overran");
  a_nb_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_NB |-> nb_k <= NB_LAST)
    else $error("neighbour slot overran");
  a_fin_exit: assert property (@(posedge clk) disable iff (rst)
    state == S_FIN |=> (state == S_FIN || state == S_IDLE))
    else $error("finish state left wrongly");
`endif

endmodule

/* rtl/lhd_dp.sv */
// ----------------------------------------------------------------------------
// lhd_dp
// Texel and coverage memories, neighbour addressing, sums, divider, output.
// ----------------------------------------------------------------------------
module lhd_dp #(
  parameter int PAGE_SIDE    = lhd_pkg::PAGE_SIDE_DEF,
  parameter int CHANNEL_BITS = lhd_pkg::CHANNEL_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [6:0]    cfg_data,
  input  lhd_pkg::req_t req_data,
  input  lhd_pkg::cmd_t cmd,
  output lhd_pkg::sts_t sts,
  output logic          res_valid,
  input  logic          res_stall,
  output lhd_pkg::res_t res_data
);
  import lhd_pkg::*;

  localparam int CB     = CHANNEL_BITS;
  localparam int AW     = CB + 3;
  localparam int DEPTH  = PAGE_SIDE * PAGE_SIDE;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CIDX_W = ADDR_W + 1;
  localparam int SIDE_W = $clog2(PAGE_SIDE + 1);
  localparam int WIDE   = (CB > 16) ? CB : 16;

  logic [3:0] pass_reg;
  logic [6:0] side_reg;
  logic [3:0] pass_cnt;

  logic [3*CB-1:0] texel_mem [DEPTH];
  logic            cov_a [DEPTH];
  logic            cov_b [DEPTH];
  logic [3*CB-1:0] texel_q;
  logic            cova_q, covb_q, cov_q;
  logic            cur;

  logic [CIDX_W-1:0] cidx;
  logic [SIDE_W-1:0] x, y, esid;
  logic              ccov, nbv_d, rd_oob;
  logic [3:0]        cnt;
  logic [AW-1:0]     acc [3];
  logic [3:0]        rem [3];

  logic              host_ok, fill, rd_en, tex_we, cov_we, cov_wd;
  logic [ADDR_W-1:0] raddr, waddr, host_addr, nb_addr;
  logic [3*CB-1:0]   tex_wd;
  logic [1:0]        dx, dy;
  logic              nb_in;
  logic [CIDX_W-1:0] row_base, nb_full;

  assign esid = (32'(side_reg) > PAGE_SIDE) ? SIDE_W'(PAGE_SIDE) : SIDE_W'(side_reg);
  assign host_ok   = 32'(req_data.texel_index) < DEPTH;
  assign host_addr = ADDR_W'(req_data.texel_index);
  assign fill      = !ccov && (cnt != 4'd0);
  assign cov_q     = cur ? covb_q : cova_q;

  // neighbour position and page bounds
  assign dx = nb_dx(cmd.nb_k);
  assign dy = nb_dy(cmd.nb_k);
  always_comb begin
    nb_in = 1'b1;
    if (dx == OFF_NEG && x == '0) nb_in = 1'b0;
    if (dx == OFF_POS && x + SIDE_W'(1) >= esid) nb_in = 1'b0;
    if (dy == OFF_NEG && y == '0) nb_in = 1'b0;
    if (dy == OFF_POS && y + SIDE_W'(1) >= esid) nb_in = 1'b0;
    case (dy)
      OFF_NEG: row_base = cidx - CIDX_W'(esid);
      OFF_POS: row_base = cidx + CIDX_W'(esid);
      default: row_base = cidx;
    endcase
    case (dx)
      OFF_NEG: nb_full = row_base - CIDX_W'(1);
      OFF_POS: nb_full = row_base + CIDX_W'(1);
      default: nb_full = row_base;
    endcase
  end
  assign nb_addr = nb_full[ADDR_W-1:0];

  always_comb begin
    rd_en = cmd.host_rd || cmd.cen_rd || cmd.tail_rd ||
            (cmd.nb_step && cmd.nb_k != NB_LAST);
    if (cmd.host_rd) begin
      raddr = host_addr;
    end else if (cmd.nb_step) begin
      raddr = nb_addr;
    end else begin
      raddr = cidx[ADDR_W-1:0];
    end
    tex_we = (cmd.host_wr && host_ok) || (cmd.wb && fill);
    cov_we = cmd.host_wr ? host_ok : (cmd.wb || cmd.tail_wr);
    waddr  = cmd.host_wr ? host_addr : cidx[ADDR_W-1:0];
    if (cmd.host_wr) begin
      tex_wd = {CB'(req_data.red_in), CB'(req_data.green_in), CB'(req_data.blue_in)};
      cov_wd = req_data.covered_in;
    end else begin
      tex_wd = {acc[0][CB-1:0], acc[1][CB-1:0], acc[2][CB-1:0]};
      cov_wd = cmd.tail_wr ? cov_q : (ccov || fill);
    end
  end

  // host writes land in the current coverage, pass writes in the other one
  always_ff @(posedge clk) begin
    if (tex_we) texel_mem[waddr] <= tex_wd;
    if (cov_we && (cmd.host_wr ? !cur : cur)) cov_a[waddr] <= cov_wd;
    if (cov_we && (cmd.host_wr ? cur : !cur)) cov_b[waddr] <= cov_wd;
    if (rd_en) begin
      texel_q <= texel_mem[raddr];
      cova_q  <= cov_a[raddr];
      covb_q  <= cov_b[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pass_reg <= PASS_COUNT_RST;
      side_reg <= SIDE_IN_USE_RST;
      pass_cnt <= '0;
      cur      <= 1'b0;
      cidx     <= '0;
      x        <= '0;
      y        <= '0;
    end else begin
      if (cfg_we && cfg_index == REG_PASS_COUNT) pass_reg <= cfg_data[3:0];
      if (cfg_we && cfg_index == REG_SIDE_IN_USE) side_reg <= cfg_data;
      if (cmd.run_init) pass_cnt <= '0;
      if (cmd.pass_end) begin
        pass_cnt <= pass_cnt + 4'd1;
        cur      <= !cur;
      end
      if (cmd.pass_init) begin
        cidx <= '0;
        x    <= '0;
        y    <= '0;
      end else if (cmd.wb) begin
        cidx <= cidx + CIDX_W'(1);
        if (x + SIDE_W'(1) == esid) begin
          x <= '0;
          y <= y + SIDE_W'(1);
        end else begin
          x <= x + SIDE_W'(1);
        end
      end else if (cmd.tail_wr) begin
        cidx <= cidx + CIDX_W'(1);
      end
    end
  end

  // neighbour sums, then a restoring divide by the count, a bit a cycle
  always_ff @(posedge clk) begin
    if (cmd.host_rd) rd_oob <= !host_ok;
    if (cmd.nb_step) begin
      nbv_d <= nb_in;
      if (cmd.nb_k == 4'd0) begin
        ccov <= cov_q;
        cnt  <= '0;
        for (int c = 0; c < 3; c++) acc[c] <= '0;
      end else if (nbv_d && cov_q) begin
        cnt <= cnt + 4'd1;
        for (int c = 0; c < 3; c++) begin
          acc[c] <= acc[c] + AW'(texel_q[(2-c)*CB +: CB]);
        end
      end
    end
    if (cmd.div_init) begin
      for (int c = 0; c < 3; c++) rem[c] <= '0;
    end
    if (cmd.div_step) begin
      for (int c = 0; c < 3; c++) begin
        if ({rem[c], acc[c][AW-1]} >= {1'b0, cnt}) begin
          rem[c] <= 4'({rem[c], acc[c][AW-1]} - {1'b0, cnt});
          acc[c] <= {acc[c][AW-2:0], 1'b1};
        end else begin
          rem[c] <= {rem[c][2:0], acc[c][AW-1]};
          acc[c] <= {acc[c][AW-2:0], 1'b0};
        end
      end
    end
  end

  logic [WIDE-1:0] r_ext, g_ext, b_ext;
  assign r_ext = WIDE'(texel_q[2*CB +: CB]);
  assign g_ext = WIDE'(texel_q[CB +: CB]);
  assign b_ext = WIDE'(texel_q[0 +: CB]);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.load_rd || cmd.load_fin) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_fin) begin
      res_data             <= '0;
      res_data.result_kind <= RESULT_DONE;
    end else if (cmd.load_rd) begin
      res_data.result_kind <= RESULT_READ;
      res_data.red_out     <= rd_oob ? 16'd0 : r_ext[15:0];
      res_data.green_out   <= rd_oob ? 16'd0 : g_ext[15:0];
      res_data.blue_out    <= rd_oob ? 16'd0 : b_ext[15:0];
      res_data.covered_out <= rd_oob ? 1'b0 : cov_q;
    end
  end

  always_comb begin
    sts.passes_done = pass_cnt == pass_reg;
    sts.side_zero   = esid == '0;
    sts.ccov        = ccov;
    sts.cnt_zero    = cnt == 4'd0;
    sts.last_texel  = (x + SIDE_W'(1) == esid) && (y + SIDE_W'(1) == esid);
    sts.tail_done   = 32'(cidx) == DEPTH;
    sts.out_free    = !res_valid || !res_stall;
  end

endmodule

/* rtl/lightmap_hole_dilation.sv */
// ----------------------------------------------------------------------------
// lightmap_hole_dilation
// Square RGB lightmap page with coverage; fills holes by 3x3 neighbour mean.
// ----------------------------------------------------------------------------
// A texel write is done in idle; a texel read passes a read state and returns one result.
// A run returns a single finished result after pass_count passes. Each pass walks
// the side*side texels in order through one shared memory read port: a centre read,
// nine neighbour reads, a collect step, a decision and a write back per texel, plus
// a bit-serial divide of the CHANNEL_BITS+3 bit sums when the texel gets filled.
// After the texels, each pass copies coverage for the remaining
// PAGE_SIDE*PAGE_SIDE - side*side entries, a read and a write for each.
// Every texel of the page in use must be written before a run.
module lightmap_hole_dilation #(
  parameter int PAGE_SIDE    = lhd_pkg::PAGE_SIDE_DEF,
  parameter int CHANNEL_BITS = lhd_pkg::CHANNEL_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [6:0]    cfg_data,
  input  logic          req_valid,
  output logic          req_stall,
  input  lhd_pkg::req_t req_data,
  output logic          res_valid,
  input  logic          res_stall,
  output lhd_pkg::res_t res_data
);
  import lhd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lhd_ctrl #(
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_mode (req_data.mode),
    .req_stall(req_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  lhd_dp #(
    .PAGE_SIDE   (PAGE_SIDE),
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .req_data (req_data),
    .cmd      (cmd),
    .sts      (sts),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_data (res_data)
  );

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for lightmap_hole_dilation: loads texel pages, runs
// dilation under several pass and side settings and checks every read-back
// and run-finished result against a behavioural predictor of the page.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import lhd_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int DEPTH = 4096;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   cfg_we = 1'b0;
  logic   cfg_index = REG_PASS_COUNT;
  logic [6:0] cfg_data = '0;
  logic   req_valid = 1'b0;
  logic   req_stall;
  req_t   req_data = '0;
  logic   res_valid;
  logic   res_stall = 1'b1;
  res_t   res_data;

  lightmap_hole_dilation dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .req_valid(req_valid), .req_stall(req_stall),
    .req_data(req_data), .res_valid(res_valid), .res_stall(res_stall),
    .res_data(res_data)
  );

  // predictor copy of the page and registers
  logic [15:0] page_r [DEPTH];
  logic [15:0] page_g [DEPTH];
  logic [15:0] page_b [DEPTH];
  bit          cov_now [DEPTH];
  bit          cov_nxt [DEPTH];
  logic [3:0]  pass_cfg = PASS_COUNT_RST;
  logic [6:0]  side_cfg = SIDE_IN_USE_RST;

  // stimulus-side record of which entries hold defined data
  bit   loaded [DEPTH];

  req_t pending [$];
  res_t texel_results [$];
  int   offered = 0;
  int   accepted = 0;
  int   errors = 0;
  bit   req_taken = 1'b0;
  int   burst_left = 1;
  int   gap_left = 0;
  bit   hold_req = 1'b0;
  bit   hold_done = 1'b0;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  task automatic dilate_page(input int side);
    int n, x, y, dx, dy, nx, ny, ni, cnt;
    logic [19:0] ar, ag, ab;
    n = side * side;
    for (int i = 0; i < n; i++) cov_nxt[i] = cov_now[i];
    for (y = 0; y < side; y++) begin
      for (x = 0; x < side; x++) begin
        if (!cov_now[y*side+x]) begin
          ar = '0; ag = '0; ab = '0; cnt = 0;
          for (dy = -1; dy <= 1; dy++) begin
            for (dx = -1; dx <= 1; dx++) begin
              nx = x + dx; ny = y + dy;
              if (nx >= 0 && ny >= 0 && nx < side && ny < side) begin
                ni = ny * side + nx;
                if (cov_now[ni]) begin
                  ar += page_r[ni]; ag += page_g[ni]; ab += page_b[ni];
                  cnt++;
                end
              end
            end
          end
          if (cnt > 0) begin
            page_r[y*side+x] = 16'(ar / cnt);
            page_g[y*side+x] = 16'(ag / cnt);
            page_b[y*side+x] = 16'(ab / cnt);
            cov_nxt[y*side+x] = 1'b1;
          end
        end
      end
    end
    for (int i = 0; i < n; i++) cov_now[i] = cov_nxt[i];
  endtask

  task automatic predict_request(input req_t rq);
    res_t r;
    int side;
    r = '0;
    case (rq.mode)
      MODE_WRITE: begin
        page_r[rq.texel_index] = rq.red_in;
        page_g[rq.texel_index] = rq.green_in;
        page_b[rq.texel_index] = rq.blue_in;
        cov_now[rq.texel_index] = rq.covered_in;
      end
      MODE_RUN: begin
        side = (side_cfg > 7'd64) ? 64 : int'(side_cfg);
        for (int p = 0; p < pass_cfg; p++) dilate_page(side);
        r.result_kind = RESULT_DONE;
        texel_results.insert(texel_results.size(), r);
      end
      MODE_READ: begin
        r.result_kind = RESULT_READ;
        r.red_out = page_r[rq.texel_index];
        r.green_out = page_g[rq.texel_index];
        r.blue_out = page_b[rq.texel_index];
        r.covered_out = cov_now[rq.texel_index];
        texel_results.insert(texel_results.size(), r);
      end
      default: ;
    endcase
  endtask

  // driver: acceptance and prediction at the rising edge
  always @(posedge clk) begin
    if (!rst && req_valid && !req_stall) begin
      predict_request(req_data);
      accepted <= accepted + 1;
      req_taken <= 1'b1;
    end else begin
      req_taken <= 1'b0;
    end
  end

  // driver: bursts and gaps, new request at the falling edge
  always @(negedge clk) begin
    if (!(req_valid && !req_taken)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        req_valid <= 1'b0;
      end else if (pending.size() > 0) begin
        req_data <= pending.pop_front();
        req_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern, with one long hold-off on request
  int stall_mode = 0;
  int stall_left = 0;
  int hold_left = 0;
  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      res_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      res_stall <= (hold_left > 1);
    end else begin
      if (stall_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        stall_left <= $urandom_range(1, 60);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        0: res_stall <= 1'b0;
        1: res_stall <= 1'($urandom_range(0, 1));
        default: res_stall <= ($urandom_range(0, 4) != 0);
      endcase
    end
  end

  // monitor
  always @(posedge clk) begin
    res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (texel_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", res_data);
      end else begin
        want = texel_results.pop_front();
        if (want.result_kind !== res_data.result_kind || want.red_out !== res_data.red_out ||
            want.green_out !== res_data.green_out || want.blue_out !== res_data.blue_out ||
            want.covered_out !== res_data.covered_out) begin
          errors++;
          if (errors <= 10)
            $display("expected %0d %h %h %h %0d, got %0d %h %h %h %0d",
                     want.result_kind, want.red_out, want.green_out, want.blue_out,
                     want.covered_out, res_data.result_kind, res_data.red_out,
                     res_data.green_out, res_data.blue_out, res_data.covered_out);
        end
      end
    end
  end

  task automatic push_request(input logic [1:0] mode, input int idx, input logic [15:0] r,
                              input logic [15:0] g, input logic [15:0] b, input bit cov);
    req_t rq;
    rq.mode = mode;
    rq.texel_index = 12'(idx);
    rq.red_in = r; rq.green_in = g; rq.blue_in = b;
    rq.covered_in = cov;
    if (mode == MODE_WRITE) loaded[idx] = 1'b1;
    pending.insert(pending.size(), rq);
    offered++;
  endtask

  task automatic write_random(input int idx, input int cov_pct);
    push_request(MODE_WRITE, idx, 16'($urandom), 16'($urandom), 16'($urandom),
                 $urandom_range(0, 99) < cov_pct);
  endtask

  task automatic read_random;
    int idx;
    do idx = $urandom_range(0, DEPTH - 1); while (!loaded[idx]);
    push_request(MODE_READ, idx, 16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
  endtask

  // extra settle time covers a write still in flight after the last result
  task automatic wait_idle;
    wait (accepted == offered && texel_results.size() == 0);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [6:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    if (idx == REG_PASS_COUNT) pass_cfg = val[3:0];
    else side_cfg = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // load the page, then runs with random traffic and read-back
  task automatic run_phase(input int passes, input int side, input int runs,
                           input int cov_pct, input int noise);
    int s, n;
    wait_idle();
    write_reg(REG_PASS_COUNT, 7'(passes));
    write_reg(REG_SIDE_IN_USE, 7'(side));
    s = (side > 64) ? 64 : side;
    n = s * s;
    for (int i = 0; i < n; i++) write_random(i, cov_pct);
    for (int k = 0; k < runs; k++) begin
      for (int j = 0; j < noise; j++) begin
        case ($urandom_range(0, 9))
          0, 1, 2: write_random((n > 0 && $urandom_range(0, 1)) ? $urandom_range(0, n - 1)
                                : $urandom_range(0, DEPTH - 1), cov_pct);
          3: push_request(MODE_UNUSED, $urandom_range(0, DEPTH - 1), 16'($urandom),
                          16'($urandom), 16'($urandom), 1'($urandom));
          default: read_random();
        endcase
      end
      push_request(MODE_RUN, $urandom_range(0, DEPTH - 1), 16'($urandom), 16'($urandom),
                   16'($urandom), 1'($urandom));
      if (n <= 64) begin
        for (int i = 0; i < n; i++)
          push_request(MODE_READ, i, '0, '0, '0, 1'b0);
      end else begin
        repeat (150) push_request(MODE_READ, $urandom_range(0, n - 1), '0, '0, '0, 1'b0);
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, every mode, unused mode, far index
    write_reg(REG_PASS_COUNT, 7'd1);
    write_reg(REG_SIDE_IN_USE, 7'd2);
    push_request(MODE_WRITE, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    push_request(MODE_WRITE, 1, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    push_request(MODE_WRITE, 2, 16'h8001, 16'h7FFE, 16'h0001, 1'b1);
    push_request(MODE_WRITE, 3, 16'h1234, 16'hFFFF, 16'h0000, 1'b0);
    push_request(MODE_WRITE, 4095, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b1);
    push_request(MODE_UNUSED, 4095, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    push_request(MODE_READ, 4095, '0, '0, '0, 1'b0);
    push_request(MODE_READ, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    push_request(MODE_RUN, 4095, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    for (int i = 0; i < 4; i++) push_request(MODE_READ, i, '0, '0, '0, 1'b0);
    push_request(MODE_RUN, 0, '0, '0, '0, 1'b0);
    push_request(MODE_READ, 1, '0, '0, '0, 1'b0);

    run_phase(0, 5, 1, 30, 10);
    run_phase(15, 6, 1, 5, 10);
    run_phase(2, 1, 2, 50, 10);
    run_phase(3, 0, 2, 50, 20);

    // long receiver hold-off against a stream of reads
    wait_idle();
    hold_req = 1'b1;
    repeat (200) read_random();

    run_phase(1, 18, 1, 20, 20);
    for (int k = 0; k < 5; k++)
      run_phase($urandom_range(0, 4), $urandom_range(1, 8), 2,
                ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(5, 60), 25);

    wait_idle();
    repeat (100) @(negedge clk);
    if (texel_results.size() != 0) errors++;
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/lhd_pkg.sv
rtl/lhd_ctrl.sv
rtl/lhd_dp.sv
rtl/lightmap_hole_dilation.sv
dv/tb.sv
